// ----- rtl/positional_list_store_top_macros.svh -----
// Assertion macros for the positional list store.
`ifndef POSITIONAL_LIST_STORE_TOP_MACROS_SVH
`define POSITIONAL_LIST_STORE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PLIS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("positional list store: assertion failed");

// Next-cycle implication, checked outside reset.
`define PLIS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("positional list store: assertion failed");

`endif

// ----- rtl/plis_pkg.sv -----
`default_nettype none
package plis_pkg;
	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = IDX_W + 1;
	localparam int DATA_W = 32;
	localparam int CMD_W  = 2;
	localparam int POS_W  = 7;
	localparam int STAT_W = 2;
	localparam int GRP    = 8;
	localparam int NGRP   = DEPTH / GRP;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_READ   = 2'd1,
		CMD_REMOVE = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef struct packed {
		logic             ins;
		logic             rem;
		logic             rd;
		logic [IDX_W-1:0] pos_idx;
		logic [CNT_W-1:0] cnt;
	} cell_ctl_t;
endpackage
`default_nettype wire

// ----- rtl/plis_cmd_if.sv -----
`default_nettype none
interface plis_cmd_if;
	logic                                 valid;
	logic                                 ready;
	logic [plis_pkg::CMD_W-1:0]           command;
	logic [plis_pkg::POS_W-1:0]           position;
	logic signed [plis_pkg::DATA_W-1:0]   value;

	modport source (output valid, output command, output position, output value, input ready);
	modport sink (input valid, input command, input position, input value, output ready);
endinterface
`default_nettype wire

// ----- rtl/plis_rsp_if.sv -----
`default_nettype none
interface plis_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [plis_pkg::DATA_W-1:0]   read_value;
	logic [plis_pkg::STAT_W-1:0]          status;
	logic [plis_pkg::CNT_W-1:0]           entry_count;
	logic                                 is_empty;

	modport source (output valid, output read_value, output status, output entry_count,
		output is_empty, input ready);
	modport sink (input valid, input read_value, input status, input entry_count,
		input is_empty, output ready);
endinterface
`default_nettype wire

// ----- rtl/positional_list_store_top.sv -----
// Ordered list of up to 64 signed 32-bit entries addressed by 1-based
// position, held in a row of 64 cells that each keep one entry and shift
// it to a neighbor on insert or remove. One command beat gives one result
// beat with status, entry count and empty flag. After acceptance a command
// is decoded, updates the cells and takes the first level of the read-select
// OR tree; then the second level of the tree goes into the output register.
// The next command is accepted once the previous one has left the cell row
// and the tree stage. A result waiting in the output register keeps the
// command in the tree stage from leaving until the result is taken, and so
// holds back the command after it. An invalid position or unknown command
// returns status 1 and leaves the list unchanged; an insert into a full list
// returns status 2. Reset clears the count; no clearing pass is run.
`default_nettype none
`include "positional_list_store_top_macros.svh"
module positional_list_store_top (
	input  wire logic     clk,
	input  wire logic     arst_n,
	plis_cmd_if.sink      cmd,
	plis_rsp_if.source    rsp
);
	logic                                 s1_v_q;
	logic                                 s2_v_q;
	logic                                 out_v_q;
	logic [plis_pkg::CNT_W-1:0]           count_q;

	logic [plis_pkg::CMD_W-1:0]           cmd_s1;
	logic [plis_pkg::POS_W-1:0]           pos_s1;
	logic signed [plis_pkg::DATA_W-1:0]   value_s1;

	plis_pkg::status_t                    status_s2;
	logic [plis_pkg::CNT_W-1:0]           count_s2;
	logic signed [plis_pkg::DATA_W-1:0]   part_s2 [plis_pkg::NGRP];

	logic signed [plis_pkg::DATA_W-1:0]   rd_value_q;
	plis_pkg::status_t                    status_q;
	logic [plis_pkg::CNT_W-1:0]           entry_count_q;

	logic                                 acc;
	logic                                 s2_go;
	logic                                 pos_ok_ins;
	logic                                 pos_ok_acc;
	logic                                 full;
	plis_pkg::status_t                    status_d;
	plis_pkg::cell_ctl_t                  ctl;
	logic [plis_pkg::CNT_W-1:0]           count_d;
	logic signed [plis_pkg::DATA_W-1:0]   part_d [plis_pkg::NGRP];
	logic signed [plis_pkg::DATA_W-1:0]   rd_final;

	logic signed [plis_pkg::DATA_W-1:0]   cell_data [plis_pkg::DEPTH];
	logic signed [plis_pkg::DATA_W-1:0]   cell_rd   [plis_pkg::DEPTH];

	assign cmd.ready = !s1_v_q && !s2_v_q;
	assign acc       = cmd.valid && cmd.ready;
	assign s2_go     = s2_v_q && (!out_v_q || rsp.ready);

	// decode the command against the current count
	always_comb begin
		pos_ok_ins  = (pos_s1 != '0) && (pos_s1 <= (count_q + plis_pkg::CNT_W'(1)));
		pos_ok_acc  = (pos_s1 != '0) && (pos_s1 <= count_q);
		full        = (count_q == plis_pkg::CNT_W'(plis_pkg::DEPTH));
		status_d    = plis_pkg::ST_OK;
		ctl.ins     = 1'b0;
		ctl.rem     = 1'b0;
		ctl.rd      = 1'b0;
		ctl.pos_idx = plis_pkg::IDX_W'(pos_s1 - plis_pkg::POS_W'(1));
		ctl.cnt     = count_q;
		count_d     = count_q;
		unique case (cmd_s1)
			plis_pkg::CMD_INSERT: begin
				if (!pos_ok_ins) begin
					status_d = plis_pkg::ST_BAD_POS;
				end else if (full) begin
					status_d = plis_pkg::ST_FULL;
				end else begin
					ctl.ins = s1_v_q;
					count_d = count_q + plis_pkg::CNT_W'(1);
				end
			end
			plis_pkg::CMD_READ: begin
				if (!pos_ok_acc) begin
					status_d = plis_pkg::ST_BAD_POS;
				end else begin
					ctl.rd = s1_v_q;
				end
			end
			plis_pkg::CMD_REMOVE: begin
				if (!pos_ok_acc) begin
					status_d = plis_pkg::ST_BAD_POS;
				end else begin
					ctl.rem = s1_v_q;
					count_d = count_q - plis_pkg::CNT_W'(1);
				end
			end
			default: begin
				status_d = plis_pkg::ST_BAD_POS;
			end
		endcase
	end

	for (genvar g = 0; g < plis_pkg::DEPTH; g++) begin : g_cell
		logic signed [plis_pkg::DATA_W-1:0] prev_w;
		logic signed [plis_pkg::DATA_W-1:0] next_w;
		if (g == 0) begin : g_first
			assign prev_w = '0;
		end else begin : g_prev
			assign prev_w = cell_data[g-1];
		end
		if (g == plis_pkg::DEPTH - 1) begin : g_last
			assign next_w = '0;
		end else begin : g_next
			assign next_w = cell_data[g+1];
		end
		plis_cell u_cell (
			.clk       (clk),
			.idx       (plis_pkg::IDX_W'(g)),
			.ctl       (ctl),
			.value     (value_s1),
			.prev_data (prev_w),
			.next_data (next_w),
			.data      (cell_data[g]),
			.rd_data   (cell_rd[g])
		);
	end

	always_comb begin
		for (int k = 0; k < plis_pkg::NGRP; k++) begin
			part_d[k] = '0;
			for (int j = 0; j < plis_pkg::GRP; j++) begin
				part_d[k] = part_d[k] | cell_rd[k*plis_pkg::GRP + j];
			end
		end
		rd_final = '0;
		for (int k = 0; k < plis_pkg::NGRP; k++) begin
			rd_final = rd_final | part_s2[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
			count_q <= '0;
		end else begin
			s1_v_q <= acc;
			if (s1_v_q) begin
				s2_v_q  <= 1'b1;
				count_q <= count_d;
			end else if (s2_go) begin
				s2_v_q <= 1'b0;
			end
			if (s2_go) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1   <= cmd.command;
			pos_s1   <= cmd.position;
			value_s1 <= cmd.value;
		end
		if (s1_v_q) begin
			status_s2 <= status_d;
			count_s2  <= count_d;
			part_s2   <= part_d;
		end
		if (s2_go) begin
			rd_value_q    <= rd_final;
			status_q      <= status_s2;
			entry_count_q <= count_s2;
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.read_value  = rd_value_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = entry_count_q;
	assign rsp.is_empty    = (entry_count_q == '0);

	`PLIS_ASSERT_IMP(a_count_max, 1'b1, count_q <= plis_pkg::CNT_W'(plis_pkg::DEPTH))
	`PLIS_ASSERT_IMP(a_one_in_flight, s1_v_q, !s2_v_q)
	`PLIS_ASSERT_IMP(a_full_only_at_depth, s2_v_q && status_s2 == plis_pkg::ST_FULL,
		count_s2 == plis_pkg::CNT_W'(plis_pkg::DEPTH))
	`PLIS_ASSERT_NXT(a_insert_counts, ctl.ins, count_q == $past(count_q) + plis_pkg::CNT_W'(1))
endmodule
`default_nettype wire

// ----- rtl/plis_cell.sv -----
`default_nettype none
module plis_cell (
	input  wire logic                                clk,
	input  wire logic [plis_pkg::IDX_W-1:0]          idx,
	input  wire plis_pkg::cell_ctl_t                 ctl,
	input  wire logic signed [plis_pkg::DATA_W-1:0]  value,
	input  wire logic signed [plis_pkg::DATA_W-1:0]  prev_data,
	input  wire logic signed [plis_pkg::DATA_W-1:0]  next_data,
	output logic signed [plis_pkg::DATA_W-1:0]       data,
	output logic signed [plis_pkg::DATA_W-1:0]       rd_data
);
	logic signed [plis_pkg::DATA_W-1:0] data_q;
	logic [plis_pkg::CNT_W-1:0]         idx_w;
	logic                               at_pos;
	logic                               above_pos;

	always_comb begin
		idx_w     = {1'b0, idx};
		at_pos    = (idx == ctl.pos_idx);
		above_pos = (idx > ctl.pos_idx);
	end

	// shift up on insert, shift down on remove, else hold
	always_ff @(posedge clk) begin
		priority if (ctl.ins && at_pos) begin
			data_q <= value;
		end else if (ctl.ins && above_pos && idx_w <= ctl.cnt) begin
			data_q <= prev_data;
		end else if (ctl.rem && (at_pos || above_pos)
				&& (idx_w + plis_pkg::CNT_W'(1)) < ctl.cnt) begin
			data_q <= next_data;
		end else begin
			data_q <= data_q;
		end
	end

	assign data    = data_q;
	assign rd_data = (ctl.rd && at_pos) ? data_q : '0;
endmodule
`default_nettype wire

// ----- test/list_store_checker.sv -----
`timescale 1ns / 100ps
module list_store_checker
	import plis_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	plis_cmd_if       cmd_mon,
	plis_rsp_if       rsp_mon,
	output int        mismatches,
	output int        outstanding
);
	typedef struct {
		logic signed [DATA_W-1:0] read_value;
		status_t                  status;
		logic [CNT_W-1:0]         entry_count;
		logic                     is_empty;
	} list_result_t;

	logic signed [DATA_W-1:0] shadow_list[$];
	list_result_t             expected_results[$];

	function automatic list_result_t apply_list_command(logic [CMD_W-1:0] op,
			logic [POS_W-1:0] pos, logic signed [DATA_W-1:0] val);
		list_result_t res;
		int           held;
		int           p;
		held = shadow_list.size();
		p = int'(pos);
		res.read_value = '0;
		res.status = ST_OK;
		case (op)
			CMD_INSERT: begin
				if (p < 1 || p > held + 1)
					res.status = ST_BAD_POS;
				else if (held >= DEPTH)
					res.status = ST_FULL;
				else
					shadow_list.insert(p - 1, val);
			end
			CMD_READ: begin
				if (p < 1 || p > held)
					res.status = ST_BAD_POS;
				else
					res.read_value = shadow_list[p - 1];
			end
			CMD_REMOVE: begin
				if (p < 1 || p > held)
					res.status = ST_BAD_POS;
				else
					shadow_list.delete(p - 1);
			end
			default: begin
				res.status = ST_BAD_POS;
			end
		endcase
		res.entry_count = CNT_W'(shadow_list.size());
		res.is_empty = (shadow_list.size() == 0);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		list_result_t want;
		if (!arst_n) begin
			shadow_list.delete();
			expected_results.delete();
			mismatches = 0;
		end else begin
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: stray beat: got %0d/%0d/%0d/%0b", $realtime,
							rsp_mon.read_value, rsp_mon.status,
							rsp_mon.entry_count, rsp_mon.is_empty);
				end else begin
					want = expected_results.pop_front();
					if (rsp_mon.read_value !== want.read_value
							|| rsp_mon.status !== want.status
							|| rsp_mon.entry_count !== want.entry_count
							|| rsp_mon.is_empty !== want.is_empty) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
								$realtime, want.read_value, want.status,
								want.entry_count, want.is_empty,
								rsp_mon.read_value, rsp_mon.status,
								rsp_mon.entry_count, rsp_mon.is_empty);
					end
				end
			end
			if (cmd_mon.valid && cmd_mon.ready)
				expected_results.push_back(apply_list_command(cmd_mon.command,
					cmd_mon.position, cmd_mon.value));
		end
		outstanding = expected_results.size();
	end
endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
module testbench;
	import plis_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1100;
	localparam int MAX_GAP = 10;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   fill;
	bit   grow;
	bit   cmd_quiet;
	bit   rsp_quiet;

	plis_cmd_if cmd_if();
	plis_rsp_if rsp_if();

	positional_list_store_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	list_store_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_mon     (cmd_if),
		.rsp_mon     (rsp_if),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int draw_gap(inout bit quiet);
		if ($urandom_range(0, 39) == 0)
			quiet = !quiet;
		return quiet ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	function automatic logic signed [DATA_W-1:0] draw_value();
		case ($urandom_range(0, 15))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] val);
		int gap;
		gap = draw_gap(cmd_quiet);
		if (gap > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_if.command  <= op;
		cmd_if.position <= pos;
		cmd_if.value    <= val;
		cmd_if.valid    <= 1'b1;
		do @(posedge clk); while (!cmd_if.ready);
		case (op)
			CMD_INSERT: if (pos >= 1 && pos <= fill + 1 && fill < DEPTH) fill++;
			CMD_REMOVE: if (pos >= 1 && pos <= fill) fill--;
			default: ;
		endcase
	endtask

	initial begin : take_results
		int gap;
		rsp_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(rsp_quiet);
			if (gap > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
		end
	end

	initial begin
		#2_000_000;
		$display("testbench: errors");
		$finish;
	end

	initial begin
		cmd_if.valid    <= 1'b0;
		cmd_if.command  <= CMD_INSERT;
		cmd_if.position <= '0;
		cmd_if.value    <= '0;
		arst_n          <= 1'b0;
		fill = 0;
		grow = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(CMD_READ, 7'd1, '0);
		send_cmd(CMD_REMOVE, 7'd1, '0);
		send_cmd(CMD_INSERT, 7'd0, 32'sd5);
		send_cmd(CMD_INSERT, 7'd2, 32'sd6);
		send_cmd(CMD_UNUSED, 7'd1, 32'sd7);
		send_cmd(CMD_INSERT, 7'd1, 32'sh7FFF_FFFF);
		send_cmd(CMD_INSERT, 7'd1, 32'sh8000_0000);
		send_cmd(CMD_INSERT, 7'd3, '1);
		send_cmd(CMD_INSERT, 7'd2, '0);
		for (int p = 1; p <= 5; p++)
			send_cmd(CMD_READ, POS_W'(p), '0);
		send_cmd(CMD_READ, 7'd127, '0);
		send_cmd(CMD_READ, 7'd0, '0);
		send_cmd(CMD_REMOVE, 7'd4, '0);
		send_cmd(CMD_REMOVE, 7'd1, '0);
		send_cmd(CMD_REMOVE, 7'd3, '0);
		send_cmd(CMD_INSERT, 7'd127, '1);
		send_cmd(CMD_REMOVE, 7'd2, '0);
		send_cmd(CMD_REMOVE, 7'd1, '0);
		send_cmd(CMD_READ, 7'd1, '0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			int               pick;
			int               ins_lim;
			logic [CMD_W-1:0] op;
			logic [POS_W-1:0] pos;
			pick = $urandom_range(0, 99);
			ins_lim = grow ? 60 : 20;
			if (pick < 8) begin
				op  = CMD_W'($urandom_range(0, 3));
				pos = POS_W'($urandom_range(0, 127));
			end else begin
				pick = $urandom_range(0, 99);
				if (fill == 0 || pick < ins_lim) begin
					op  = CMD_INSERT;
					pos = POS_W'($urandom_range(1, fill + 1));
				end else begin
					op  = (pick < ins_lim + 20) ? CMD_READ : CMD_REMOVE;
					pos = POS_W'($urandom_range(1, fill));
				end
			end
			send_cmd(op, pos, draw_value());
			if (fill == DEPTH && $urandom_range(0, 3) == 0)
				grow = 1'b0;
			else if (fill == 0)
				grow = 1'b1;
			else if ($urandom_range(0, 199) == 0)
				grow = !grow;
		end
		cmd_if.valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule
